### rtl/cross_shard_edge_router_core_defines.svh
// assertion macros for the cross-shard edge router
// no dependencies
`ifndef CROSS_SHARD_EDGE_ROUTER_CORE_DEFINES_SVH
`define CROSS_SHARD_EDGE_ROUTER_CORE_DEFINES_SVH
`define CSER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cser assertion failed");
`define CSER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cser assertion failed");
`endif

### rtl/cser_pkg.sv
// package for the cross-shard edge router: widths, codes, hash
// no dependencies
package cser_pkg;
    localparam int MapEntries = 256;
    localparam int MsgCap     = 256;
    localparam logic [63:0] FnvOffset = 64'd1469598103934665603;
    localparam logic [63:0] FnvPrime  = 64'd1099511628211;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_ROUTE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_LOCAL    = 3'd2,
        ST_MESSAGE  = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_MSG_FULL = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] task_id;
        logic [15:0] shard_num;
        logic [63:0] due_tick;
        logic        due_valid;
        logic [63:0] from_task;
        logic [63:0] to_task;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] from_shard;
        logic [15:0] to_shard;
        logic [63:0] msg_hash;
        logic [63:0] arrive_tick;
    } out_beat_t;
endpackage

### rtl/cser_in_if.sv
// input channel of the cross-shard edge router
// depends on cser_pkg
interface cser_in_if;
    logic valid;
    logic ready;
    cser_pkg::in_beat_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
    modport monitor(input valid, input data, input ready);
endinterface

### rtl/cser_out_if.sv
// output channel of the cross-shard edge router
// depends on cser_pkg
interface cser_out_if;
    logic valid;
    logic ready;
    cser_pkg::out_beat_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
    modport monitor(input valid, input data, input ready);
endinterface

### rtl/cross_shard_edge_router_core.sv
// Cross-shard edge router. Clear and add pass through the done and emit states,
// waiting in emit until the output register is free. A route scans the task
// table one entry per cycle through a single synchronous memory read port and
// then hashes; the block is held for the scan of up to entry_count entries
// and the hash. The scan ends early once both ends are found. The pair hash
// takes two 64x64 multiplies, each built from three 32x32 partial products.
// A new beat is taken while the previous result waits in the output register;
// a result finding that register still occupied holds the block until it drains.
// depends on cser_pkg, cser_in_if, cser_out_if, the defines header
`include "cross_shard_edge_router_core_defines.svh"
module cross_shard_edge_router_core #(
    parameter int MAP_ENTRIES = cser_pkg::MapEntries,
    parameter int MSG_CAP     = cser_pkg::MsgCap
) (
    input  logic       clk,
    input  logic       rst_n,
    cser_in_if.sink    in_ch,
    cser_out_if.source out_ch
);
    localparam int AW = $clog2(MAP_ENTRIES);
    localparam int CW = $clog2(MAP_ENTRIES + 1);
    localparam int MW = $clog2(MSG_CAP + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_HASH  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [63:0] task_id;
        logic [15:0] shard;
        logic [63:0] due;
        logic        due_ok;
    } entry_t;

    entry_t mem [MAP_ENTRIES];
    entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [MW-1:0] msg_reg, msg_next;
    cser_pkg::in_beat_t beat_reg, beat_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] chk_reg, chk_next;
    logic chk_valid_reg, chk_valid_next;
    logic f_found_reg, f_found_next, t_found_reg, t_found_next;
    entry_t f_ent_reg, f_ent_next, t_ent_reg, t_ent_next;
    logic [2:0] mstep_reg, mstep_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] acc_reg, acc_next;
    logic out_valid_reg, out_valid_next;
    cser_pkg::out_beat_t out_reg, out_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata;
    logic [63:0] pp;
    logic [31:0] pa, pb;
    logic slot_free;
    logic [63:0] tick;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_comb
    begin
        case (mstep_reg[1:0])
            2'd0: begin pa = h_reg[31:0];  pb = cser_pkg::FnvPrime[31:0];  end
            2'd1: begin pa = h_reg[63:32]; pb = cser_pkg::FnvPrime[31:0];  end
            2'd2: begin pa = h_reg[31:0];  pb = cser_pkg::FnvPrime[63:32]; end
            default: begin pa = 32'd0; pb = 32'd0; end
        endcase
        pp = {32'd0, pa} * {32'd0, pb};
    end

    always_comb
    begin
        tick = 64'd0;
        if (f_ent_reg.due_ok)
        begin
            tick = f_ent_reg.due;
        end
        if (t_ent_reg.due_ok && t_ent_reg.due > tick)
        begin
            tick = t_ent_reg.due;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        msg_next = msg_reg;
        beat_next = beat_reg;
        scan_next = scan_reg;
        chk_next = scan_reg;
        chk_valid_next = 1'b0;
        f_found_next = f_found_reg;
        t_found_next = t_found_reg;
        f_ent_next = f_ent_reg;
        t_ent_next = t_ent_reg;
        mstep_next = mstep_reg;
        h_next = h_reg;
        acc_next = acc_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        we = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata.task_id = beat_reg.task_id;
        wdata.shard = beat_reg.shard_num;
        wdata.due = beat_reg.due_tick;
        wdata.due_ok = beat_reg.due_valid;
        raddr = scan_reg[AW-1:0];

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (chk_valid_reg)
        begin
            if (!f_found_reg && rd_data_reg.task_id == beat_reg.from_task)
            begin
                f_found_next = 1'b1;
                f_ent_next = rd_data_reg;
            end
            if (!t_found_reg && rd_data_reg.task_id == beat_reg.to_task)
            begin
                t_found_next = 1'b1;
                t_ent_next = rd_data_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    beat_next = in_ch.data;
                    f_found_next = 1'b0;
                    t_found_next = 1'b0;
                    f_ent_next = '0;
                    t_ent_next = '0;
                    scan_next = '0;
                    case (cser_pkg::cmd_t'(in_ch.data.command))
                        cser_pkg::CMD_CLEAR, cser_pkg::CMD_ADD: state_next = S_DONE;
                        cser_pkg::CMD_ROUTE: state_next = S_SCAN;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= count_reg || (f_found_next && t_found_next))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    chk_valid_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                h_next = cser_pkg::FnvOffset ^ beat_reg.from_task;
                acc_next = 64'd0;
                mstep_next = 3'd0;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                if (mstep_reg[1:0] == 2'd0)
                begin
                    acc_next = pp;
                end
                else if (mstep_reg[1:0] == 2'd1 || mstep_reg[1:0] == 2'd2)
                begin
                    acc_next = acc_reg + {pp[31:0], 32'd0};
                end
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg[1:0] == 2'd3)
                begin
                    if (!mstep_reg[2])
                    begin
                        h_next = acc_reg ^ beat_reg.to_task;
                        mstep_next = 3'd4;
                    end
                    else
                    begin
                        h_next = acc_reg;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    state_next = S_IDLE;
                    case (cser_pkg::cmd_t'(beat_reg.command))
                        cser_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            msg_next = '0;
                            out_next.status = cser_pkg::ST_CLEARED;
                        end
                        cser_pkg::CMD_ADD:
                        begin
                            if (count_reg >= CW'(MAP_ENTRIES))
                            begin
                                out_next.status = cser_pkg::ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                count_next = count_reg + 1'b1;
                                out_next.status = cser_pkg::ST_ADDED;
                            end
                        end
                        default:
                        begin
                            out_next.from_shard = f_found_reg ? f_ent_reg.shard : 16'd0;
                            out_next.to_shard = t_found_reg ? t_ent_reg.shard : 16'd0;
                            if (!f_found_reg || !t_found_reg || f_ent_reg.shard == 16'd0
                                || t_ent_reg.shard == 16'd0)
                            begin
                                out_next.status = cser_pkg::ST_UNKNOWN;
                            end
                            else if (f_ent_reg.shard == t_ent_reg.shard)
                            begin
                                out_next.status = cser_pkg::ST_LOCAL;
                            end
                            else if (msg_reg >= MW'(MSG_CAP))
                            begin
                                out_next.status = cser_pkg::ST_MSG_FULL;
                            end
                            else
                            begin
                                out_next.status = cser_pkg::ST_MESSAGE;
                                out_next.msg_hash = h_reg;
                                out_next.arrive_tick = tick;
                                msg_next = msg_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            msg_reg <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            f_found_reg <= 1'b0;
            t_found_reg <= 1'b0;
            mstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            msg_reg <= msg_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            f_found_reg <= f_found_next;
            t_found_reg <= t_found_next;
            mstep_reg <= mstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        scan_reg <= scan_next;
        chk_reg <= chk_next;
        f_ent_reg <= f_ent_next;
        t_ent_reg <= t_ent_next;
        h_reg <= h_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    `CSER_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(MAP_ENTRIES))
    `CSER_ASSERT_IMPL(a_msg_range, clk, rst_n, 1'b1, msg_reg <= MW'(MSG_CAP))
    `CSER_ASSERT_IMPL(a_chk_bound, clk, rst_n, chk_valid_reg, chk_reg < count_reg)
    `CSER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ch.ready, out_valid_reg && $stable(out_reg))
endmodule
